// File: src/sic_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the segment intersection classifier
// no dependencies; used by every module of the block

package sic_pkg;

    // coordinate width default and fixed field widths
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int CLASS_W         = 3;

    // point slots
    localparam int PT_A0 = 0;
    localparam int PT_A1 = 1;
    localparam int PT_B0 = 2;
    localparam int PT_B1 = 3;
    localparam int NUM_PTS = 4;

    // difference vectors needed by the four orientation tests
    localparam int D_A    = 0;  // a0 - a1
    localparam int D_B    = 1;  // b0 - b1
    localparam int D_A0B0 = 2;  // a0 - b0
    localparam int D_A0B1 = 3;  // a0 - b1
    localparam int D_B0A0 = 4;  // b0 - a0
    localparam int D_B0A1 = 5;  // b0 - a1
    localparam int NUM_DIFFS = 6;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE         = 3'd0,
        CLS_CROSS        = 3'd1,
        CLS_TOUCH        = 3'd2,
        CLS_SHARED_END   = 3'd3,
        CLS_FULL_OVERLAP = 3'd4,
        CLS_COL_SHARED   = 3'd5,
        CLS_OVERLAP      = 3'd6,
        CLS_COL_DISJOINT = 3'd7
    } t_class;

    // sign of one orientation test; both low means collinear
    typedef struct packed {
        logic pos;
        logic neg;
    } t_orient;

    // endpoint equality and bounding box results
    typedef struct packed {
        logic eq_a0b0;
        logic eq_a0b1;
        logic eq_a1b0;
        logic eq_a1b1;
        logic box_a_b0;  // b0 inside box of a
        logic box_a_b1;
        logic box_b_a0;  // a0 inside box of b
        logic box_b_a1;
    } t_pair_flags;

endpackage

// File: src/segment_intersection_classifier.sv
`timescale 1ns / 1ps
// Segment pair classifier, four register stages. One pair of segments is taken
// per clock cycle while o_in_stall is low; its result passes the prep, product,
// compare and result registers, and leaves when the output side is not stalling.
// The eight signed products of the orientation tests fill their own stage,
// with the product compare in the stage after it. Stalls collapse bubbles: a
// stage moves whenever it is empty or the stage behind it moves, so the input
// keeps taking transactions while the pipeline has a free slot, even with a
// result waiting at the output register. Coordinates are the low COORD_WIDTH
// bits of each field, sign extended, or the whole field zero extended when
// COORD_WIDTH is wider. The block keeps no state between transactions.
// depends on sic_pkg, sic_prep, sic_orient, sic_classify

module segment_intersection_classifier #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [sic_pkg::FIELD_W-1:0] i_a_start_x,
    input  logic [sic_pkg::FIELD_W-1:0] i_a_start_y,
    input  logic [sic_pkg::FIELD_W-1:0] i_a_end_x,
    input  logic [sic_pkg::FIELD_W-1:0] i_a_end_y,
    input  logic [sic_pkg::FIELD_W-1:0] i_b_start_x,
    input  logic [sic_pkg::FIELD_W-1:0] i_b_start_y,
    input  logic [sic_pkg::FIELD_W-1:0] i_b_end_x,
    input  logic [sic_pkg::FIELD_W-1:0] i_b_end_y,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_intersects,
    output logic [sic_pkg::CLASS_W-1:0] o_class_code
);

    localparam int CW = COORD_WIDTH;

    // per stage valid bits and move enables
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    logic [sic_pkg::FIELD_W-1:0] raw [2*sic_pkg::NUM_PTS];
    logic signed [CW:0]          diff_x [sic_pkg::NUM_DIFFS];
    logic signed [CW:0]          diff_y [sic_pkg::NUM_DIFFS];
    sic_pkg::t_pair_flags        flags_s1;
    sic_pkg::t_pair_flags        r_flags_s2;
    sic_pkg::t_pair_flags        r_flags_s3;
    sic_pkg::t_orient            ta;
    sic_pkg::t_orient            tb;
    sic_pkg::t_orient            sa;
    sic_pkg::t_orient            sb;
    sic_pkg::t_class             out_class;

    // a stage may load when it is empty or its content moves on
    assign en4 = !r_v4 || !i_out_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // field order matches the point slots: x then y for a0, a1, b0, b1
    assign raw[0] = i_a_start_x;
    assign raw[1] = i_a_start_y;
    assign raw[2] = i_a_end_x;
    assign raw[3] = i_a_end_y;
    assign raw[4] = i_b_start_x;
    assign raw[5] = i_b_start_y;
    assign raw[6] = i_b_end_x;
    assign raw[7] = i_b_end_y;

    // stage 1: differences and compare flags
    sic_prep #(
        .COORD_WIDTH(CW)
    ) u_prep (
        .i_clk    (i_clk),
        .i_en     (en1),
        .i_raw    (raw),
        .o_diff_x (diff_x),
        .o_diff_y (diff_y),
        .o_flags  (flags_s1)
    );

    // compare flags ride alongside the product and compare stages
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_flags_s2 <= flags_s1;
        end
        if (en3) begin
            r_flags_s3 <= r_flags_s2;
        end
    end

    // stages 2 and 3: orientation of b0, b1 against a and of a0, a1 against b
    sic_orient #(
        .COORD_WIDTH(CW)
    ) u_orient_ta (
        .i_clk    (i_clk),
        .i_en_mul (en2),
        .i_en_cmp (en3),
        .i_ux     (diff_x[sic_pkg::D_A]),
        .i_uy     (diff_y[sic_pkg::D_A]),
        .i_vx     (diff_x[sic_pkg::D_A0B0]),
        .i_vy     (diff_y[sic_pkg::D_A0B0]),
        .o_orient (ta)
    );

    sic_orient #(
        .COORD_WIDTH(CW)
    ) u_orient_tb (
        .i_clk    (i_clk),
        .i_en_mul (en2),
        .i_en_cmp (en3),
        .i_ux     (diff_x[sic_pkg::D_A]),
        .i_uy     (diff_y[sic_pkg::D_A]),
        .i_vx     (diff_x[sic_pkg::D_A0B1]),
        .i_vy     (diff_y[sic_pkg::D_A0B1]),
        .o_orient (tb)
    );

    sic_orient #(
        .COORD_WIDTH(CW)
    ) u_orient_sa (
        .i_clk    (i_clk),
        .i_en_mul (en2),
        .i_en_cmp (en3),
        .i_ux     (diff_x[sic_pkg::D_B]),
        .i_uy     (diff_y[sic_pkg::D_B]),
        .i_vx     (diff_x[sic_pkg::D_B0A0]),
        .i_vy     (diff_y[sic_pkg::D_B0A0]),
        .o_orient (sa)
    );

    sic_orient #(
        .COORD_WIDTH(CW)
    ) u_orient_sb (
        .i_clk    (i_clk),
        .i_en_mul (en2),
        .i_en_cmp (en3),
        .i_ux     (diff_x[sic_pkg::D_B]),
        .i_uy     (diff_y[sic_pkg::D_B]),
        .i_vx     (diff_x[sic_pkg::D_B0A1]),
        .i_vy     (diff_y[sic_pkg::D_B0A1]),
        .o_orient (sb)
    );

    // stage 4: result register that drives the output channel
    sic_classify u_classify (
        .i_clk        (i_clk),
        .i_en         (en4),
        .i_ta         (ta),
        .i_tb         (tb),
        .i_sa         (sa),
        .i_sb         (sb),
        .i_flags      (r_flags_s3),
        .o_intersects (o_intersects),
        .o_class      (out_class)
    );

    assign o_class_code = out_class;

endmodule

// File: src/sic_prep.sv
`timescale 1ns / 1ps
// first stage: coordinate extension, difference vectors, endpoint and box compares
// depends on sic_pkg

module sic_prep #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [sic_pkg::FIELD_W-1:0] i_raw [2*sic_pkg::NUM_PTS],
    output logic signed [COORD_WIDTH:0] o_diff_x [sic_pkg::NUM_DIFFS],
    output logic signed [COORD_WIDTH:0] o_diff_y [sic_pkg::NUM_DIFFS],
    output sic_pkg::t_pair_flags      o_flags
);

    localparam int CW   = COORD_WIDTH;
    localparam int FW   = sic_pkg::FIELD_W;
    localparam int PI_W = $clog2(sic_pkg::NUM_PTS);

    logic signed [CW-1:0] pt_x [sic_pkg::NUM_PTS];
    logic signed [CW-1:0] pt_y [sic_pkg::NUM_PTS];
    logic signed [CW:0]   n_diff_x [sic_pkg::NUM_DIFFS];
    logic signed [CW:0]   n_diff_y [sic_pkg::NUM_DIFFS];
    sic_pkg::t_pair_flags n_flags;

    // upper field bits are ignored when the coordinate is narrower than the field
    for (genvar k = 0; k < 2*sic_pkg::NUM_PTS; k++) begin : g_ext
        logic signed [CW-1:0] ext;
        if (CW <= FW) begin : g_narrow
            assign ext = i_raw[k][CW-1:0];
        end else begin : g_wide
            assign ext = {{(CW-FW){1'b0}}, i_raw[k]};
        end
        if (k % 2 == 0) begin : g_x
            assign pt_x[k/2] = ext;
        end else begin : g_y
            assign pt_y[k/2] = ext;
        end
    end

    function automatic logic signed [CW:0] sub(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
        logic signed [CW:0] ea;
        logic signed [CW:0] eb;
        ea = {a[CW-1], a};
        eb = {b[CW-1], b};
        return ea - eb;
    endfunction

    // inclusive range test without forming min and max first
    function automatic logic in_range(input logic signed [CW-1:0] d0,
                                      input logic signed [CW-1:0] d1,
                                      input logic signed [CW-1:0] p);
        return (p >= d0 && p <= d1) || (p >= d1 && p <= d0);
    endfunction

    function automatic logic in_box(input int unsigned i0, input int unsigned i1,
                                    input int unsigned ip);
        return in_range(pt_x[i0[PI_W-1:0]], pt_x[i1[PI_W-1:0]], pt_x[ip[PI_W-1:0]])
            && in_range(pt_y[i0[PI_W-1:0]], pt_y[i1[PI_W-1:0]], pt_y[ip[PI_W-1:0]]);
    endfunction

    function automatic logic same_pt(input int unsigned i0, input int unsigned i1);
        return pt_x[i0[PI_W-1:0]] == pt_x[i1[PI_W-1:0]]
            && pt_y[i0[PI_W-1:0]] == pt_y[i1[PI_W-1:0]];
    endfunction

    always_comb begin
        n_diff_x[sic_pkg::D_A]    = sub(pt_x[sic_pkg::PT_A0], pt_x[sic_pkg::PT_A1]);
        n_diff_y[sic_pkg::D_A]    = sub(pt_y[sic_pkg::PT_A0], pt_y[sic_pkg::PT_A1]);
        n_diff_x[sic_pkg::D_B]    = sub(pt_x[sic_pkg::PT_B0], pt_x[sic_pkg::PT_B1]);
        n_diff_y[sic_pkg::D_B]    = sub(pt_y[sic_pkg::PT_B0], pt_y[sic_pkg::PT_B1]);
        n_diff_x[sic_pkg::D_A0B0] = sub(pt_x[sic_pkg::PT_A0], pt_x[sic_pkg::PT_B0]);
        n_diff_y[sic_pkg::D_A0B0] = sub(pt_y[sic_pkg::PT_A0], pt_y[sic_pkg::PT_B0]);
        n_diff_x[sic_pkg::D_A0B1] = sub(pt_x[sic_pkg::PT_A0], pt_x[sic_pkg::PT_B1]);
        n_diff_y[sic_pkg::D_A0B1] = sub(pt_y[sic_pkg::PT_A0], pt_y[sic_pkg::PT_B1]);
        n_diff_x[sic_pkg::D_B0A0] = sub(pt_x[sic_pkg::PT_B0], pt_x[sic_pkg::PT_A0]);
        n_diff_y[sic_pkg::D_B0A0] = sub(pt_y[sic_pkg::PT_B0], pt_y[sic_pkg::PT_A0]);
        n_diff_x[sic_pkg::D_B0A1] = sub(pt_x[sic_pkg::PT_B0], pt_x[sic_pkg::PT_A1]);
        n_diff_y[sic_pkg::D_B0A1] = sub(pt_y[sic_pkg::PT_B0], pt_y[sic_pkg::PT_A1]);

        n_flags.eq_a0b0  = same_pt(sic_pkg::PT_A0, sic_pkg::PT_B0);
        n_flags.eq_a0b1  = same_pt(sic_pkg::PT_A0, sic_pkg::PT_B1);
        n_flags.eq_a1b0  = same_pt(sic_pkg::PT_A1, sic_pkg::PT_B0);
        n_flags.eq_a1b1  = same_pt(sic_pkg::PT_A1, sic_pkg::PT_B1);
        n_flags.box_a_b0 = in_box(sic_pkg::PT_A0, sic_pkg::PT_A1, sic_pkg::PT_B0);
        n_flags.box_a_b1 = in_box(sic_pkg::PT_A0, sic_pkg::PT_A1, sic_pkg::PT_B1);
        n_flags.box_b_a0 = in_box(sic_pkg::PT_B0, sic_pkg::PT_B1, sic_pkg::PT_A0);
        n_flags.box_b_a1 = in_box(sic_pkg::PT_B0, sic_pkg::PT_B1, sic_pkg::PT_A1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_diff_x <= n_diff_x;
            o_diff_y <= n_diff_y;
            o_flags  <= n_flags;
        end
    end

endmodule

// File: src/sic_orient.sv
`timescale 1ns / 1ps
// one orientation test: two products in one stage, their compare in the next
// depends on sic_pkg

module sic_orient #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en_mul,
    input  logic                        i_en_cmp,
    input  logic signed [COORD_WIDTH:0] i_ux,
    input  logic signed [COORD_WIDTH:0] i_uy,
    input  logic signed [COORD_WIDTH:0] i_vx,
    input  logic signed [COORD_WIDTH:0] i_vy,
    output sic_pkg::t_orient            o_orient
);

    localparam int PW = 2*COORD_WIDTH + 2;

    logic signed [PW-1:0] r_left;
    logic signed [PW-1:0] r_right;
    sic_pkg::t_orient     n_orient;

    // cross product halves; the compare replaces the subtraction
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_left  <= i_ux * i_vy;
            r_right <= i_vx * i_uy;
        end
    end

    always_comb begin
        n_orient.pos = r_left > r_right;
        n_orient.neg = r_left < r_right;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_cmp) begin
            o_orient <= n_orient;
        end
    end

endmodule

// File: src/sic_classify.sv
`timescale 1ns / 1ps
// last stage: intersect flag and class code from orientations and compare flags
// depends on sic_pkg

module sic_classify (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  sic_pkg::t_orient     i_ta,
    input  sic_pkg::t_orient     i_tb,
    input  sic_pkg::t_orient     i_sa,
    input  sic_pkg::t_orient     i_sb,
    input  sic_pkg::t_pair_flags i_flags,
    output logic                 o_intersects,
    output sic_pkg::t_class      o_class
);

    logic            t_differ;
    logic            s_differ;
    logic            ta_col;
    logic            tb_col;
    logic            sa_col;
    logic            sb_col;
    logic            any_shared;
    logic            both_shared;
    logic            n_intersects;
    sic_pkg::t_class n_class;

    always_comb begin
        ta_col   = !i_ta.pos && !i_ta.neg;
        tb_col   = !i_tb.pos && !i_tb.neg;
        sa_col   = !i_sa.pos && !i_sa.neg;
        sb_col   = !i_sb.pos && !i_sb.neg;
        t_differ = (i_ta.pos != i_tb.pos) || (i_ta.neg != i_tb.neg);
        s_differ = (i_sa.pos != i_sb.pos) || (i_sa.neg != i_sb.neg);

        any_shared  = i_flags.eq_a0b0 || i_flags.eq_a0b1
                   || i_flags.eq_a1b0 || i_flags.eq_a1b1;
        both_shared = (i_flags.eq_a0b0 && i_flags.eq_a1b1)
                   || (i_flags.eq_a0b1 && i_flags.eq_a1b0);

        n_intersects = (t_differ && s_differ)
                    || (ta_col && i_flags.box_a_b0)
                    || (tb_col && i_flags.box_a_b1)
                    || (sa_col && i_flags.box_b_a0)
                    || (sb_col && i_flags.box_b_a1);

        n_class = sic_pkg::CLS_NONE;
        if (i_ta.neg != i_tb.neg) begin
            // exactly one end of b on the negative side of the line of a
            if (i_sa.neg != i_sb.neg) begin
                n_class = sic_pkg::CLS_CROSS;
            end else if (i_sa.pos != i_sb.pos) begin
                n_class = sic_pkg::CLS_TOUCH;
            end
        end else if (i_ta.pos != i_tb.pos) begin
            // one end of b on the line of a
            if (any_shared) begin
                n_class = sic_pkg::CLS_SHARED_END;
            end else if (i_sa.neg != i_sb.neg) begin
                n_class = sic_pkg::CLS_TOUCH;
            end
        end else if (ta_col && tb_col) begin
            if (any_shared) begin
                n_class = both_shared ? sic_pkg::CLS_FULL_OVERLAP : sic_pkg::CLS_COL_SHARED;
            end else if (i_flags.box_a_b0 && i_flags.box_a_b1) begin
                n_class = sic_pkg::CLS_OVERLAP;
            end else begin
                n_class = sic_pkg::CLS_COL_DISJOINT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_intersects <= n_intersects;
            o_class      <= n_class;
        end
    end

endmodule

// File: src/sic_checker.sv
`timescale 1ns / 1ps
// port level checks for the segment pair classifier, bound to the top level
// depends on sic_pkg and segment_intersection_classifier

module sic_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic                        o_intersects,
    input  logic [sic_pkg::CLASS_W-1:0] o_class_code
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_intersects) && $stable(o_class_code))
        else $error("result payload changed while stalled");

    // an empty pipeline never pushes back on the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // every contact class other than none and collinear disjoint is a hit
    a_class_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_class_code != sic_pkg::CLS_NONE
            && o_class_code != sic_pkg::CLS_COL_DISJOINT |-> o_intersects)
        else $error("contact class without intersect flag");

    // nothing leaves the block right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_intersects (o_intersects),
    .o_class_code (o_class_code)
);

// File: tb/segment_intersection_classifier_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for segment_intersection_classifier: directed and random segment
// pairs under random sender gaps and receiver stalls, with a scoreboard class doing the checks
// depends on sic_pkg and segment_intersection_classifier

module segment_intersection_classifier_tb;

    localparam int CW           = sic_pkg::COORD_WIDTH_DEF;
    localparam int FW           = sic_pkg::FIELD_W;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;       // drain margin past the four-stage pipeline
    localparam int RANDOM_PAIRS [3] = '{600, 600, 550};

    typedef struct {
        logic [FW-1:0] ax0, ay0, ax1, ay1;
        logic [FW-1:0] bx0, by0, bx1, by1;
    } t_seg_pair;

    typedef struct {
        longint x;
        longint y;
    } t_point;

    typedef struct {
        logic            hit;
        sic_pkg::t_class cls;
    } t_contact;

    // prediction of the contact class plus the queue of contacts still owed by the block
    class t_contact_book;
        t_contact expected_contacts [$];
        int       mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // low CW bits of a field, sign extended
        function longint widen(logic [FW-1:0] raw);
            longint v;
            v = longint'(raw) & ((longint'(1) << CW) - 1);
            if (v[CW-1])
                v = v - (longint'(1) << CW);
            return v;
        endfunction

        // +1 counter-clockwise, -1 clockwise, 0 collinear
        function int orient(t_point p, t_point q, t_point r);
            longint lhs, rhs;
            lhs = (p.x - q.x) * (p.y - r.y);
            rhs = (p.x - r.x) * (p.y - q.y);
            if (lhs > rhs)
                return 1;
            if (lhs < rhs)
                return -1;
            return 0;
        endfunction

        function bit same_point(t_point a, t_point b);
            return a.x == b.x && a.y == b.y;
        endfunction

        // inclusive bounding box of d0..d1
        function bit in_box(t_point d0, t_point d1, t_point p);
            longint xl, xh, yl, yh;
            xl = (d0.x < d1.x) ? d0.x : d1.x;
            xh = (d0.x < d1.x) ? d1.x : d0.x;
            yl = (d0.y < d1.y) ? d0.y : d1.y;
            yh = (d0.y < d1.y) ? d1.y : d0.y;
            return p.x >= xl && p.x <= xh && p.y >= yl && p.y <= yh;
        endfunction

        function t_contact classify_pair(t_seg_pair s);
            t_point   a0, a1, b0, b1;
            int       ta, tb, sa, sb;
            bit       any_shared, both_shared;
            t_contact c;
            a0.x = widen(s.ax0); a0.y = widen(s.ay0);
            a1.x = widen(s.ax1); a1.y = widen(s.ay1);
            b0.x = widen(s.bx0); b0.y = widen(s.by0);
            b1.x = widen(s.bx1); b1.y = widen(s.by1);
            ta = orient(a0, a1, b0);
            tb = orient(a0, a1, b1);
            sa = orient(b0, b1, a0);
            sb = orient(b0, b1, a1);
            c.hit = (ta != tb && sa != sb)
                 || (ta == 0 && in_box(a0, a1, b0))
                 || (tb == 0 && in_box(a0, a1, b1))
                 || (sa == 0 && in_box(b0, b1, a0))
                 || (sb == 0 && in_box(b0, b1, a1));
            any_shared  = same_point(a0, b0) || same_point(a0, b1)
                       || same_point(a1, b0) || same_point(a1, b1);
            both_shared = (same_point(a0, b0) && same_point(a1, b1))
                       || (same_point(a0, b1) && same_point(a1, b0));
            c.cls = sic_pkg::CLS_NONE;
            if ((ta < 0) != (tb < 0)) begin
                if ((sa < 0) != (sb < 0))
                    c.cls = sic_pkg::CLS_CROSS;
                else if ((sa > 0) != (sb > 0))
                    c.cls = sic_pkg::CLS_TOUCH;
            end else if ((ta > 0) != (tb > 0)) begin
                if (any_shared)
                    c.cls = sic_pkg::CLS_SHARED_END;
                else if ((sa < 0) != (sb < 0))
                    c.cls = sic_pkg::CLS_TOUCH;
            end else if (ta == 0 && tb == 0) begin
                if (any_shared)
                    c.cls = both_shared ? sic_pkg::CLS_FULL_OVERLAP : sic_pkg::CLS_COL_SHARED;
                else if (in_box(a0, a1, b0) && in_box(a0, a1, b1))
                    c.cls = sic_pkg::CLS_OVERLAP;
                else
                    c.cls = sic_pkg::CLS_COL_DISJOINT;
            end
            return c;
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatch_count++;
        endtask

        function void note_pair(t_seg_pair s);
            expected_contacts.push_back(classify_pair(s));
        endfunction

        task check_contact(logic hit, logic [sic_pkg::CLASS_W-1:0] cls);
            t_contact e;
            if (expected_contacts.size() == 0) begin
                report_mismatch($sformatf("result hit=%b class=%0d with no pair pending", hit, cls));
            end else begin
                e = expected_contacts.pop_front();
                if (hit !== e.hit)
                    report_mismatch($sformatf("intersects %b, expected %b", hit, e.hit));
                if (cls !== e.cls)
                    report_mismatch($sformatf("class_code %0d, expected %s", cls, e.cls.name()));
            end
        endtask

        function int pending();
            return expected_contacts.size();
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [FW-1:0]               i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y;
    logic [FW-1:0]               i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic                        o_intersects;
    logic [sic_pkg::CLASS_W-1:0] o_class_code;

    t_contact_book contacts = new();
    int            in_idle_pct;     // chance in a hundred that the sender leaves a gap
    int            out_stall_pct;   // chance in a hundred that the receiver stalls
    int            cycle_count;

    segment_intersection_classifier #(
        .COORD_WIDTH (CW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_a_start_x  (i_a_start_x),
        .i_a_start_y  (i_a_start_y),
        .i_a_end_x    (i_a_end_x),
        .i_a_end_y    (i_a_end_y),
        .i_b_start_x  (i_b_start_x),
        .i_b_start_y  (i_b_start_y),
        .i_b_end_x    (i_b_end_x),
        .i_b_end_y    (i_b_end_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_intersects (o_intersects),
        .o_class_code (o_class_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[segment_intersection_classifier] ERROR");
            $finish;
        end
    end

    // receiver side: stall at random, rate set per phase
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // both handshakes are sampled at the edge, so values seen here are the pre-edge ones;
    // the input side is noted first so a pair is always queued before its result shows up
    always @(posedge i_clk) begin
        t_seg_pair s;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                s.ax0 = i_a_start_x; s.ay0 = i_a_start_y;
                s.ax1 = i_a_end_x;   s.ay1 = i_a_end_y;
                s.bx0 = i_b_start_x; s.by0 = i_b_start_y;
                s.bx1 = i_b_end_x;   s.by1 = i_b_end_y;
                contacts.note_pair(s);
            end
            if (o_out_valid && !i_out_stall)
                contacts.check_contact(o_intersects, o_class_code);
        end
    end

    function automatic t_seg_pair mk_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
        t_seg_pair s;
        s.ax0 = FW'(ax0); s.ay0 = FW'(ay0); s.ax1 = FW'(ax1); s.ay1 = FW'(ay1);
        s.bx0 = FW'(bx0); s.by0 = FW'(by0); s.bx1 = FW'(bx1); s.by1 = FW'(by1);
        return s;
    endfunction

    function automatic int span(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    // corner values of the coordinate range, with a random value now and then
    function automatic int corner();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return span(32767);
        endcase
    endfunction

    // random pair, biased toward the contact kinds that plain random data almost never hits
    function automatic t_seg_pair gen_pair();
        t_seg_pair s;
        int        kind, px, py, dx, dy, pick;
        int        t [4];
        kind = $urandom_range(99);
        px = span(16000); py = span(16000);
        dx = span(40);    dy = span(40);
        foreach (t[i])
            t[i] = span(20);
        if (kind < 15) begin
            // full field range, every bit toggles
            s = mk_pair($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
        end else if (kind < 30) begin
            // tiny grid: lots of collinear, touching and shared points
            s = mk_pair(span(3), span(3), span(3), span(3),
                        span(3), span(3), span(3), span(3));
        end else if (kind < 50) begin
            // all four points on one line
            s = mk_pair(px + t[0] * dx, py + t[0] * dy, px + t[1] * dx, py + t[1] * dy,
                        px + t[2] * dx, py + t[2] * dy, px + t[3] * dx, py + t[3] * dy);
        end else if (kind < 65) begin
            // endpoint copied from a to b, sometimes both
            s = mk_pair(span(2000), span(2000), span(2000), span(2000),
                        span(2000), span(2000), span(2000), span(2000));
            pick = $urandom_range(4);
            case (pick)
                0: begin s.bx0 = s.ax0; s.by0 = s.ay0; end
                1: begin s.bx0 = s.ax1; s.by0 = s.ay1; end
                2: begin s.bx1 = s.ax0; s.by1 = s.ay0; end
                3: begin s.bx1 = s.ax1; s.by1 = s.ay1; end
                default: begin
                    if ($urandom_range(1)) begin
                        s.bx0 = s.ax0; s.by0 = s.ay0; s.bx1 = s.ax1; s.by1 = s.ay1;
                    end else begin
                        s.bx0 = s.ax1; s.by0 = s.ay1; s.bx1 = s.ax0; s.by1 = s.ay0;
                    end
                end
            endcase
        end else if (kind < 80) begin
            // one end of b lands on the line through a, other end free
            s = mk_pair(px + t[0] * dx, py + t[0] * dy, px + t[1] * dx, py + t[1] * dy,
                        px + t[2] * dx, py + t[2] * dy, px + span(800), py + span(800));
            if ($urandom_range(1)) begin
                {s.bx0, s.bx1} = {s.bx1, s.bx0};
                {s.by0, s.by1} = {s.by1, s.by0};
            end
        end else if (kind < 90) begin
            s = mk_pair(corner(), corner(), corner(), corner(),
                        corner(), corner(), corner(), corner());
        end else begin
            s = mk_pair(span(1000), span(1000), span(1000), span(1000),
                        span(1000), span(1000), span(1000), span(1000));
        end
        return s;
    endfunction

    // one transaction on the input channel, with random gaps ahead of it
    task automatic send_pair(t_seg_pair s);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_a_start_x <= s.ax0; i_a_start_y <= s.ay0;
        i_a_end_x   <= s.ax1; i_a_end_y   <= s.ay1;
        i_b_start_x <= s.bx0; i_b_start_y <= s.by0;
        i_b_end_x   <= s.bx1; i_b_end_y   <= s.by1;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    initial begin
        t_seg_pair directed [$];

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_a_start_x <= '0; i_a_start_y <= '0; i_a_end_x <= '0; i_a_end_y <= '0;
        i_b_start_x <= '0; i_b_start_y <= '0; i_b_end_x <= '0; i_b_end_y <= '0;
        in_idle_pct   = 38;
        out_stall_pct = 84;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both segments one point at the origin, then at the most negative corner
        directed.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_pair(-32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
        // full-range diagonals crossing, then a full-range horizontal and vertical: widest products
        directed.push_back(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        directed.push_back(mk_pair(32767, 32767, -32768, 32767, 0, -32768, 0, 32767));
        // plain crossing
        directed.push_back(mk_pair(0, 0, 10, 0, 5, -5, 5, 5));
        // t-junction either way round
        directed.push_back(mk_pair(0, 0, 10, 0, 5, 0, 5, 5));
        directed.push_back(mk_pair(5, 0, 5, 5, 0, 0, 10, 0));
        // corner shared by two non-collinear segments
        directed.push_back(mk_pair(0, 0, 10, 0, 10, 0, 10, 10));
        directed.push_back(mk_pair(32767, -32768, 0, 0, 32767, -32768, -32768, 32767));
        // collinear: same segment, same segment reversed
        directed.push_back(mk_pair(0, 0, 10, 10, 0, 0, 10, 10));
        directed.push_back(mk_pair(0, 0, 10, 10, 10, 10, 0, 0));
        // collinear with one end shared
        directed.push_back(mk_pair(0, 0, 5, 5, 5, 5, 9, 9));
        // collinear, b inside a, including at full range
        directed.push_back(mk_pair(0, 0, 10, 0, 2, 0, 7, 0));
        directed.push_back(mk_pair(-32768, -32768, 32767, 32767, -1, -1, 0, 0));
        // collinear, b reaching past the end of a: disjoint class though they meet
        directed.push_back(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));
        // collinear with a gap
        directed.push_back(mk_pair(0, 0, 3, 3, 5, 5, 8, 8));
        // parallel lines, and lines that would cross beyond the segments
        directed.push_back(mk_pair(0, 0, 10, 0, 0, 1, 10, 1));
        directed.push_back(mk_pair(0, 0, 1, 1, 5, 0, 4, 1));
        // degenerate a lying on b, degenerate b off a, degenerate b at an end of a
        directed.push_back(mk_pair(3, 0, 3, 0, 0, 0, 10, 0));
        directed.push_back(mk_pair(0, 0, 10, 0, 4, 7, 4, 7));
        directed.push_back(mk_pair(32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767));
        foreach (directed[i])
            send_pair(directed[i]);

        // three idling phases: receiver-heavy stalls, sender-heavy gaps, then none
        for (int phase = 0; phase < 3; phase++) begin
            in_idle_pct   = (phase == 0) ? 38 : (phase == 1) ? 84 : 0;
            out_stall_pct = (phase == 0) ? 84 : (phase == 1) ? 38 : 0;
            for (int n = 0; n < RANDOM_PAIRS[phase]; n++)
                send_pair(gen_pair());
        end
        i_in_valid <= 1'b0;

        while (contacts.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (contacts.mismatch_count == 0 && contacts.pending() == 0)
            $display("[segment_intersection_classifier] OK");
        else
            $display("[segment_intersection_classifier] ERROR");
        $finish;
    end

endmodule

// File: files.f
src/sic_pkg.sv
src/sic_prep.sv
src/sic_orient.sv
src/sic_classify.sv
src/segment_intersection_classifier.sv
src/sic_checker.sv
tb/segment_intersection_classifier_tb.sv
